FILE: rtl/core/ywfo_pkg.sv
package ywfo_pkg;

	// Binary angle input width and the CORDIC angle accumulator (yaw * 16)
	localparam int YAW_W     = 16;
	localparam int ANGLE_W   = 21;
	// CORDIC x/y datapath in Q.16, wide enough for the gain growth
	localparam int CORDIC_W  = 19;
	localparam int CORDIC_STEPS = 16;

	localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN  = CORDIC_W'(39797);
	localparam logic signed [ANGLE_W-1:0]  QUARTER_TURN = ANGLE_W'(262144);
	localparam logic signed [ANGLE_W-1:0]  HALF_TURN    = ANGLE_W'(524288);

	// Rounded arctangent of 2^-i in angle units (full turn = 2^20)
	localparam logic signed [ANGLE_W-1:0] ATAN_UNITS [CORDIC_STEPS] = '{
		ANGLE_W'(131072), ANGLE_W'(77376), ANGLE_W'(40884), ANGLE_W'(20753),
		ANGLE_W'(10417),  ANGLE_W'(5213),  ANGLE_W'(2607),  ANGLE_W'(1304),
		ANGLE_W'(652),    ANGLE_W'(326),   ANGLE_W'(163),   ANGLE_W'(81),
		ANGLE_W'(41),     ANGLE_W'(20),    ANGLE_W'(10),    ANGLE_W'(5)
	};

	// Foot side codes
	localparam logic signed [1:0] SIDE_LEFT      = 2'sb01;
	localparam logic signed [1:0] SIDE_RIGHT     = 2'sb11;
	localparam logic signed [1:0] SIDE_RIGHT_ALT = 2'sb10;

	// Register map, word index
	typedef enum logic [1:0] {
		REG_FWD_GAIN = 2'd0,
		REG_FWD_BIAS = 2'd1,
		REG_LAT_GAIN = 2'd2,
		REG_LAT_BIAS = 2'd3
	} reg_idx_t;

	// Rotation state handed from cell to cell
	typedef struct packed {
		logic signed [CORDIC_W-1:0] x;
		logic signed [CORDIC_W-1:0] y;
		logic signed [ANGLE_W-1:0]  t;
		logic                       flip;
		logic signed [1:0]          side;
	} cordic_t;

endpackage

FILE: rtl/core/ywfo_cordic_cell.sv
module ywfo_cordic_cell #(
	parameter int STEP      = 0,
	parameter int DATA_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  ywfo_pkg::cordic_t           up_rot,
	input  logic signed [DATA_BITS-1:0] up_vx,
	input  logic signed [DATA_BITS-1:0] up_vy,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output ywfo_pkg::cordic_t           dn_rot,
	output logic signed [DATA_BITS-1:0] dn_vx,
	output logic signed [DATA_BITS-1:0] dn_vy
);

	logic                                  en;
	logic                                  valid_q;
	logic signed [ywfo_pkg::CORDIC_W-1:0]  x_in;
	logic signed [ywfo_pkg::CORDIC_W-1:0]  y_in;
	logic signed [ywfo_pkg::ANGLE_W-1:0]   t_in;
	logic signed [ywfo_pkg::CORDIC_W-1:0]  dx;
	logic signed [ywfo_pkg::CORDIC_W-1:0]  dy;
	ywfo_pkg::cordic_t                     rot_d;
	ywfo_pkg::cordic_t                     rot_q;
	logic signed [DATA_BITS-1:0]           vx_q;
	logic signed [DATA_BITS-1:0]           vy_q;

	// Stage advances when empty or when the next cell takes its request
	assign en       = !valid_q || dn_ready;
	assign up_ready = en;

	// One micro-rotation, direction from the sign of the residual angle
	always_comb begin
		x_in = up_rot.x;
		y_in = up_rot.y;
		t_in = up_rot.t;
		dx   = y_in >>> STEP;
		dy   = x_in >>> STEP;
		rot_d = up_rot;
		if (!t_in[ywfo_pkg::ANGLE_W-1]) begin
			rot_d.x = x_in - dx;
			rot_d.y = y_in + dy;
			rot_d.t = t_in - ywfo_pkg::ATAN_UNITS[STEP];
		end else begin
			rot_d.x = x_in + dx;
			rot_d.y = y_in - dy;
			rot_d.t = t_in + ywfo_pkg::ATAN_UNITS[STEP];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && up_valid) begin
			rot_q <= rot_d;
			vx_q  <= up_vx;
			vy_q  <= up_vy;
		end
	end

	assign dn_valid = valid_q;
	assign dn_rot   = rot_q;
	assign dn_vx    = vx_q;
	assign dn_vy    = vy_q;

endmodule

FILE: rtl/core/ywfo_offset_pipe.sv
module ywfo_offset_pipe #(
	parameter int DATA_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        up_valid,
	output logic                        up_ready,
	input  ywfo_pkg::cordic_t           up_rot,
	input  logic signed [DATA_BITS-1:0] up_vx,
	input  logic signed [DATA_BITS-1:0] up_vy,
	input  logic signed [DATA_BITS-1:0] fwd_gain,
	input  logic signed [DATA_BITS-1:0] fwd_bias,
	input  logic signed [DATA_BITS-1:0] lat_gain,
	input  logic signed [DATA_BITS-1:0] lat_bias,
	output logic                        dn_valid,
	input  logic                        dn_ready,
	output logic signed [DATA_BITS-1:0] dn_x,
	output logic signed [DATA_BITS-1:0] dn_y
);

	localparam int N  = DATA_BITS;
	localparam int CW = ywfo_pkg::CORDIC_W;
	localparam int PW = CW + N;        // trig * velocity
	localparam int BW = N + 2;         // body velocity
	localparam int GW = 2 * N + 3;     // gain product with headroom
	localparam int FW = N + 8;         // saturated body offset
	localparam int QW = CW + FW;       // trig * body offset
	localparam int SW = QW + 2;        // rotated sum with headroom

	localparam logic signed [PW+1:0] HALF_P = (PW+2)'(32768);
	localparam logic signed [GW-1:0] HALF_G = GW'(2048);
	localparam logic signed [SW-1:0] HALF_S = SW'(32768);

	function automatic logic signed [FW-1:0] sat_body(input logic signed [GW-1:0] v);
		if (v[GW-1:FW-1] == {(GW-FW+1){v[GW-1]}})
			return v[FW-1:0];
		return {v[GW-1], {(FW-1){~v[GW-1]}}};
	endfunction

	function automatic logic signed [N-1:0] sat_out(input logic signed [SW-1:0] v);
		if (v[SW-1:N-1] == {(SW-N+1){v[SW-1]}})
			return v[N-1:0];
		return {v[SW-1], {(N-1){~v[SW-1]}}};
	endfunction

	logic en1, en2, en3, en4, en5, en6;
	logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;

	// Stall chain: each stage moves when empty or when the next one moves
	assign en6      = !v6_q || dn_ready;
	assign en5      = !v5_q || en6;
	assign en4      = !v4_q || en5;
	assign en3      = !v3_q || en4;
	assign en2      = !v2_q || en3;
	assign en1      = !v1_q || en2;
	assign up_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q <= 1'b0;
			v2_q <= 1'b0;
			v3_q <= 1'b0;
			v4_q <= 1'b0;
			v5_q <= 1'b0;
			v6_q <= 1'b0;
		end else begin
			if (en1) v1_q <= up_valid;
			if (en2) v2_q <= v1_q;
			if (en3) v3_q <= v2_q;
			if (en4) v4_q <= v3_q;
			if (en5) v5_q <= v4_q;
			if (en6) v6_q <= v5_q;
		end
	end

	// Stage 1: undo the half-turn fold, project velocity onto the yaw axes
	logic signed [CW-1:0] c_in, s_in, x_in, y_in;
	logic signed [CW-1:0] c_s1, s_s1;
	logic signed [PW-1:0] cvx_s1, svy_s1, cvy_s1, svx_s1;
	logic signed [1:0]    side_s1;

	always_comb begin
		x_in = up_rot.x;
		y_in = up_rot.y;
		c_in = up_rot.flip ? -x_in : x_in;
		s_in = up_rot.flip ? -y_in : y_in;
	end

	always_ff @(posedge clk) begin
		if (en1 && up_valid) begin
			c_s1    <= c_in;
			s_s1    <= s_in;
			cvx_s1  <= c_in * up_vx;
			svy_s1  <= s_in * up_vy;
			cvy_s1  <= c_in * up_vy;
			svx_s1  <= s_in * up_vx;
			side_s1 <= up_rot.side;
		end
	end

	// Stage 2: body-frame velocity, rounded to Q4.12
	logic signed [PW+1:0] bx_sum, by_sum, bx_sh, by_sh;
	logic signed [CW-1:0] c_s2, s_s2;
	logic signed [BW-1:0] bx_s2, by_s2;
	logic signed [1:0]    side_s2;

	always_comb begin
		bx_sum = PW'(cvx_s1) + PW'(svy_s1) + HALF_P;
		by_sum = PW'(cvy_s1) - PW'(svx_s1) + HALF_P;
		bx_sh  = bx_sum >>> 16;
		by_sh  = by_sum >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en2 && v1_q) begin
			c_s2    <= c_s1;
			s_s2    <= s_s1;
			bx_s2   <= bx_sh[BW-1:0];
			by_s2   <= by_sh[BW-1:0];
			side_s2 <= side_s1;
		end
	end

	// Stage 3: gain products and side-signed lateral bias
	logic signed [GW-2:0] pf_s3, pl_s3;
	logic signed [N:0]    sb_c, sb_s3;
	logic signed [CW-1:0] c_s3, s_s3;

	always_comb begin
		case (side_s2)
			ywfo_pkg::SIDE_LEFT:  sb_c = (N+1)'(lat_bias);
			ywfo_pkg::SIDE_RIGHT: sb_c = -((N+1)'(lat_bias));
			default:              sb_c = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en3 && v2_q) begin
			c_s3  <= c_s2;
			s_s3  <= s_s2;
			pf_s3 <= fwd_gain * bx_s2;
			pl_s3 <= lat_gain * by_s2;
			sb_s3 <= sb_c;
		end
	end

	// Stage 4: round, add bias, clamp to the wide body range
	logic signed [GW-1:0] f_rnd, l_rnd, f_sum, l_sum;
	logic signed [FW-1:0] f_s4, l_s4;
	logic signed [CW-1:0] c_s4, s_s4;

	always_comb begin
		f_rnd = (GW'(pf_s3) + HALF_G) >>> 12;
		l_rnd = (GW'(pl_s3) + HALF_G) >>> 12;
		f_sum = f_rnd + GW'(fwd_bias);
		l_sum = l_rnd + GW'(sb_s3);
	end

	always_ff @(posedge clk) begin
		if (en4 && v3_q) begin
			c_s4 <= c_s3;
			s_s4 <= s_s3;
			f_s4 <= sat_body(f_sum);
			l_s4 <= sat_body(l_sum);
		end
	end

	// Stage 5: products for the rotation back to world
	logic signed [QW-1:0] cf_s5, sl_s5, sf_s5, cl_s5;

	always_ff @(posedge clk) begin
		if (en5 && v4_q) begin
			cf_s5 <= c_s4 * f_s4;
			sl_s5 <= s_s4 * l_s4;
			sf_s5 <= s_s4 * f_s4;
			cl_s5 <= c_s4 * l_s4;
		end
	end

	// Stage 6: round and saturate into the output register
	logic signed [SW-1:0] ox_sum, oy_sum;
	logic signed [N-1:0]  ox_s6, oy_s6;

	always_comb begin
		ox_sum = (SW'(cf_s5) - SW'(sl_s5) + HALF_S) >>> 16;
		oy_sum = (SW'(sf_s5) + SW'(cl_s5) + HALF_S) >>> 16;
	end

	always_ff @(posedge clk) begin
		if (en6 && v5_q) begin
			ox_s6 <= sat_out(ox_sum);
			oy_s6 <= sat_out(oy_sum);
		end
	end

	assign dn_valid = v6_q;
	assign dn_x     = ox_s6;
	assign dn_y     = oy_s6;

endmodule

FILE: rtl/core/yaw_frame_foothold_offset_unit.sv
// Yaw-frame foothold offset unit.
// Request channel (req_valid/req_ready) carries a world-frame commanded
// velocity, the base yaw as a 16-bit binary angle and the foot side. Each
// request yields one result on rsp_valid/rsp_ready: the world-frame foothold
// offset, Q4.12, saturated to DATA_BITS.
// The yaw goes through a chain of 16 CORDIC cells, one micro-rotation per
// cell, followed by a six-stage arithmetic pipe (projection, gains, bias and
// clamp, rotation back, rounding). Throughput is one request per cycle,
// except while the pipe is full and stalled by a low rsp_ready.
// Every stage has its own valid bit and only holds when its successor is
// full and stalled, so req_ready stays high while bubbles remain; a stalled
// receiver fills the pipe, after which req_ready drops until rsp_ready.
// Gains and biases sit behind an APB-style port (word index = paddr[3:2]),
// reset to zero, and may only be written while no request is in flight.
// Reset clears all valid bits and the configuration registers; no clearing pass is needed.
module yaw_frame_foothold_offset_unit #(
	parameter int DATA_BITS = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        req_valid,
	output logic                        req_ready,
	input  logic signed [DATA_BITS-1:0] command_velocity_x,
	input  logic signed [DATA_BITS-1:0] command_velocity_y,
	input  logic signed [15:0]          base_yaw,
	input  logic signed [1:0]           foot_side,
	output logic                        rsp_valid,
	input  logic                        rsp_ready,
	output logic signed [DATA_BITS-1:0] offset_x,
	output logic signed [DATA_BITS-1:0] offset_y
);

	localparam int STEPS = ywfo_pkg::CORDIC_STEPS;
	localparam int AW    = ywfo_pkg::ANGLE_W;

	// Configuration registers
	logic signed [DATA_BITS-1:0] fwd_gain_q, fwd_bias_q, lat_gain_q, lat_bias_q;
	ywfo_pkg::reg_idx_t          reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = ywfo_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_gain_q <= '0;
			fwd_bias_q <= '0;
			lat_gain_q <= '0;
			lat_bias_q <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				ywfo_pkg::REG_FWD_GAIN: fwd_gain_q <= pwdata[DATA_BITS-1:0];
				ywfo_pkg::REG_FWD_BIAS: fwd_bias_q <= pwdata[DATA_BITS-1:0];
				ywfo_pkg::REG_LAT_GAIN: lat_gain_q <= pwdata[DATA_BITS-1:0];
				ywfo_pkg::REG_LAT_BIAS: lat_bias_q <= pwdata[DATA_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			ywfo_pkg::REG_FWD_GAIN: prdata = 32'(unsigned'(fwd_gain_q));
			ywfo_pkg::REG_FWD_BIAS: prdata = 32'(unsigned'(fwd_bias_q));
			ywfo_pkg::REG_LAT_GAIN: prdata = 32'(unsigned'(lat_gain_q));
			ywfo_pkg::REG_LAT_BIAS: prdata = 32'(unsigned'(lat_bias_q));
			default:                prdata = '0;
		endcase
	end

	// Entry: scale yaw to angle units, fold into +-quarter turn, clamp side
	logic signed [AW-1:0] t_raw;
	ywfo_pkg::cordic_t    rot_entry;

	always_comb begin
		t_raw          = {base_yaw[15], base_yaw, 4'b0000};
		rot_entry.x    = ywfo_pkg::CORDIC_GAIN;
		rot_entry.y    = '0;
		rot_entry.t    = t_raw;
		rot_entry.flip = 1'b0;
		rot_entry.side = (foot_side == ywfo_pkg::SIDE_RIGHT_ALT) ?
		                 ywfo_pkg::SIDE_RIGHT : foot_side;
		if (t_raw > ywfo_pkg::QUARTER_TURN) begin
			rot_entry.t    = t_raw - ywfo_pkg::HALF_TURN;
			rot_entry.flip = 1'b1;
		end else if (t_raw < -ywfo_pkg::QUARTER_TURN) begin
			rot_entry.t    = t_raw + ywfo_pkg::HALF_TURN;
			rot_entry.flip = 1'b1;
		end
	end

	// CORDIC cell chain
	logic                        ch_valid [STEPS+1];
	logic                        ch_ready [STEPS+1];
	ywfo_pkg::cordic_t           ch_rot   [STEPS+1];
	logic signed [DATA_BITS-1:0] ch_vx    [STEPS+1];
	logic signed [DATA_BITS-1:0] ch_vy    [STEPS+1];

	assign ch_valid[0] = req_valid;
	assign ch_rot[0]   = rot_entry;
	assign ch_vx[0]    = command_velocity_x;
	assign ch_vy[0]    = command_velocity_y;
	assign req_ready   = ch_ready[0];

	for (genvar i = 0; i < STEPS; i++) begin : g_cell
		ywfo_cordic_cell #(
			.STEP      (i),
			.DATA_BITS (DATA_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (ch_valid[i]),
			.up_ready (ch_ready[i]),
			.up_rot   (ch_rot[i]),
			.up_vx    (ch_vx[i]),
			.up_vy    (ch_vy[i]),
			.dn_valid (ch_valid[i+1]),
			.dn_ready (ch_ready[i+1]),
			.dn_rot   (ch_rot[i+1]),
			.dn_vx    (ch_vx[i+1]),
			.dn_vy    (ch_vy[i+1])
		);
	end

	// Gain law and rotation back to world
	ywfo_offset_pipe #(
		.DATA_BITS (DATA_BITS)
	) u_pipe (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (ch_valid[STEPS]),
		.up_ready (ch_ready[STEPS]),
		.up_rot   (ch_rot[STEPS]),
		.up_vx    (ch_vx[STEPS]),
		.up_vy    (ch_vy[STEPS]),
		.fwd_gain (fwd_gain_q),
		.fwd_bias (fwd_bias_q),
		.lat_gain (lat_gain_q),
		.lat_bias (lat_bias_q),
		.dn_valid (rsp_valid),
		.dn_ready (rsp_ready),
		.dn_x     (offset_x),
		.dn_y     (offset_y)
	);

endmodule

FILE: sim/yaw_frame_foothold_offset_unit_tb.sv
module yaw_frame_foothold_offset_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = 16;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int REQUESTS_PER_PHASE = 180;
	localparam int DRAIN_CYCLES = 30;

	// Q.16 CORDIC gain and angle units (full turn = 2^20)
	localparam longint GAIN_START = 39797;
	localparam longint QUARTER_UNITS = 262144;
	localparam longint HALF_UNITS = 524288;
	localparam longint ATAN_STEP [16] = '{
		131072, 77376, 40884, 20753, 10417, 5213, 2607, 1304,
		652, 326, 163, 81, 41, 20, 10, 5
	};

	localparam logic signed [1:0] SIDE_NONE = 2'sb00;

	typedef struct {
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
	} offset_t;

	// Expected offsets in request order, plus the gain/bias shadow
	class foothold_scoreboard;
		logic signed [DW-1:0] fwd_gain;
		logic signed [DW-1:0] fwd_bias;
		logic signed [DW-1:0] lat_gain;
		logic signed [DW-1:0] lat_bias;
		offset_t pending_offsets[$];
		int mismatch_count;

		function new();
			fwd_gain = '0;
			fwd_bias = '0;
			lat_gain = '0;
			lat_bias = '0;
			mismatch_count = 0;
		endfunction

		function void set_register(ywfo_pkg::reg_idx_t idx, logic signed [DW-1:0] val);
			case (idx)
				ywfo_pkg::REG_FWD_GAIN: fwd_gain = val;
				ywfo_pkg::REG_FWD_BIAS: fwd_bias = val;
				ywfo_pkg::REG_LAT_GAIN: lat_gain = val;
				ywfo_pkg::REG_LAT_BIAS: lat_bias = val;
				default: ;
			endcase
		endfunction

		// round half up, then floor
		function longint round_shr(longint v, int k);
			return (v + (longint'(1) << (k - 1))) >>> k;
		endfunction

		function longint clamp_bits(longint v, int bits);
			longint lim;
			lim = longint'(1) << (bits - 1);
			if (v > lim - 1)
				return lim - 1;
			if (v < -lim)
				return -lim;
			return v;
		endfunction

		// 16-step rotation-mode CORDIC, cos/sin in Q.16
		function void yaw_cos_sin(input longint yaw, output longint c, output longint s);
			longint t;
			longint x;
			longint y;
			longint dx;
			longint dy;
			bit flip;
			t = yaw * 16;
			flip = 1'b0;
			x = GAIN_START;
			y = 0;
			// fold angles beyond a quarter turn by half a turn
			if (t > QUARTER_UNITS) begin
				t -= HALF_UNITS;
				flip = 1'b1;
			end else if (t < -QUARTER_UNITS) begin
				t += HALF_UNITS;
				flip = 1'b1;
			end
			for (int i = 0; i < 16; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (t >= 0) begin
					x -= dx;
					y += dy;
					t -= ATAN_STEP[i];
				end else begin
					x += dx;
					y -= dy;
					t += ATAN_STEP[i];
				end
			end
			c = flip ? -x : x;
			s = flip ? -y : y;
		endfunction

		function void note_request(logic signed [DW-1:0] vx, logic signed [DW-1:0] vy,
				logic signed [15:0] yaw, logic signed [1:0] side);
			longint c;
			longint s;
			longint bx;
			longint by;
			longint f;
			longint l;
			longint sd;
			longint vxl;
			longint vyl;
			offset_t exp_off;
			vxl = vx;
			vyl = vy;
			sd = side;
			// code -2 behaves as the right foot
			if (sd < -1)
				sd = -1;
			yaw_cos_sin(yaw, c, s);
			// world velocity into the base yaw frame
			bx = round_shr(c * vxl + s * vyl, 16);
			by = round_shr(c * vyl - s * vxl, 16);
			// per-axis affine law, clamped to DW+8 bits
			f = round_shr(longint'(fwd_gain) * bx, 12) + longint'(fwd_bias);
			l = round_shr(longint'(lat_gain) * by, 12) + sd * longint'(lat_bias);
			f = clamp_bits(f, DW + 8);
			l = clamp_bits(l, DW + 8);
			// back to the world frame, saturated to DW bits
			exp_off.x = DW'(clamp_bits(round_shr(c * f - s * l, 16), DW));
			exp_off.y = DW'(clamp_bits(round_shr(s * f + c * l, 16), DW));
			pending_offsets.push_back(exp_off);
		endfunction

		task report_mismatch(string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			mismatch_count++;
		endtask

		task check_result(logic signed [DW-1:0] ox, logic signed [DW-1:0] oy);
			offset_t exp_off;
			if (pending_offsets.size() == 0) begin
				report_mismatch($sformatf("unexpected result x=%0d y=%0d", ox, oy));
			end else begin
				exp_off = pending_offsets.pop_front();
				if (ox !== exp_off.x)
					report_mismatch($sformatf("offset_x got %0d want %0d", ox, exp_off.x));
				if (oy !== exp_off.y)
					report_mismatch($sformatf("offset_y got %0d want %0d", oy, exp_off.y));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic req_valid;
	logic req_ready;
	logic signed [DW-1:0] command_velocity_x;
	logic signed [DW-1:0] command_velocity_y;
	logic signed [15:0] base_yaw;
	logic signed [1:0] foot_side;
	logic rsp_valid;
	logic rsp_ready;
	logic signed [DW-1:0] offset_x;
	logic signed [DW-1:0] offset_y;

	int send_idle_pct = 0;
	int rsp_idle_pct = 0;
	int rsp_hold_cycles = 0;
	int stall_cycles = 0;

	foothold_scoreboard sb = new();

	yaw_frame_foothold_offset_unit #(
		.DATA_BITS(DW)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.command_velocity_x(command_velocity_x),
		.command_velocity_y(command_velocity_y),
		.base_yaw(base_yaw),
		.foot_side(foot_side),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.offset_x(offset_x),
		.offset_y(offset_y)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// APB write: setup, access, register taken at the access edge
	task automatic apb_write(input ywfo_pkg::reg_idx_t idx, input logic signed [DW-1:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(val);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_register(idx, val);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic signed [DW-1:0] fg, input logic signed [DW-1:0] fb,
			input logic signed [DW-1:0] lg, input logic signed [DW-1:0] lb);
		apb_write(ywfo_pkg::REG_FWD_GAIN, fg);
		apb_write(ywfo_pkg::REG_FWD_BIAS, fb);
		apb_write(ywfo_pkg::REG_LAT_GAIN, lg);
		apb_write(ywfo_pkg::REG_LAT_BIAS, lb);
	endtask

	// offer one request, with random gaps ahead of it
	task automatic send_request(input logic signed [DW-1:0] vx, input logic signed [DW-1:0] vy,
			input logic signed [15:0] yaw, input logic signed [1:0] side);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		command_velocity_x <= vx;
		command_velocity_y <= vy;
		base_yaw <= yaw;
		foot_side <= side;
		do @(posedge clk); while (!req_ready);
		sb.note_request(vx, vy, yaw, side);
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain_requests();
		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.pending_offsets.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic signed [DW-1:0] pick_velocity();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sd32767;
			2, 3: return DW'($urandom_range(8191)) - 16'sd4096;
			default: return DW'($urandom);
		endcase
	endfunction

	function automatic logic signed [15:0] pick_yaw();
		case ($urandom_range(15))
			0: return 16'sd16384;
			1: return 16'sd16385;
			2: return -16'sd16384;
			3: return -16'sd16385;
			4: return 16'sh8000;
			5: return 16'sd32767;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic signed [DW-1:0] pick_gain(bit narrow);
		if (narrow)
			return DW'($urandom_range(16383)) - 16'sd8192;
		return DW'($urandom);
	endfunction

	// receiver: random stalls, or a long hold-off when asked
	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold_cycles > 0) begin
				rsp_ready <= 1'b0;
				rsp_hold_cycles--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	// result checking and stall counting
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready)
				sb.check_result(offset_x, offset_y);
			if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	// watchdog
	initial begin
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		command_velocity_x = '0;
		command_velocity_y = '0;
		base_yaw = '0;
		foot_side = SIDE_NONE;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: everything should come out zero
		send_request(16'sd4096, 16'sd0, 16'sd0, ywfo_pkg::SIDE_LEFT);
		send_request(16'sh8000, 16'sd32767, 16'sh8000, ywfo_pkg::SIDE_RIGHT);
		drain_requests();

		// unit gains, quarter-turn folding, all side codes
		write_all(16'sd4096, 16'sd1024, 16'sd4096, 16'sd2048);
		send_request(16'sd4096, 16'sd0, 16'sd0, ywfo_pkg::SIDE_LEFT);
		send_request(16'sd4096, 16'sd0, 16'sd16384, ywfo_pkg::SIDE_RIGHT);
		send_request(16'sd0, 16'sd4096, 16'sd16385, SIDE_NONE);
		send_request(-16'sd4096, 16'sd2048, -16'sd16384, ywfo_pkg::SIDE_RIGHT_ALT);
		send_request(-16'sd4096, 16'sd2048, -16'sd16385, ywfo_pkg::SIDE_LEFT);
		send_request(16'sd1000, -16'sd1000, 16'sd32767, ywfo_pkg::SIDE_RIGHT);
		send_request(16'sd1000, -16'sd1000, 16'sh8000, ywfo_pkg::SIDE_LEFT);
		send_request(16'sd0, 16'sd0, 16'sd8192, SIDE_NONE);
		send_request(16'sd32767, 16'sd32767, 16'sd5000, ywfo_pkg::SIDE_LEFT);
		send_request(16'sh8000, 16'sh8000, -16'sd5000, ywfo_pkg::SIDE_RIGHT_ALT);
		send_request(-16'sd1, -16'sd1, 16'sd1, ywfo_pkg::SIDE_RIGHT);
		drain_requests();

		// extreme gains and biases drive both saturation stages
		write_all(16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000);
		send_request(16'sd32767, 16'sh8000, 16'sd0, ywfo_pkg::SIDE_LEFT);
		send_request(16'sh8000, 16'sd32767, 16'sd12000, ywfo_pkg::SIDE_RIGHT);
		send_request(16'sd32767, 16'sd32767, -16'sd20000, ywfo_pkg::SIDE_RIGHT_ALT);
		send_request(16'sh8000, 16'sh8000, 16'sd30000, SIDE_NONE);
		drain_requests();
		write_all(16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767);
		send_request(16'sd32767, 16'sd32767, 16'sd0, ywfo_pkg::SIDE_LEFT);
		send_request(16'sh8000, 16'sd0, -16'sd16384, ywfo_pkg::SIDE_RIGHT);
		drain_requests();

		// random phases: sender-light/receiver-heavy idling, swapped, then none
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				1: write_all(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
				2: write_all(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
				3: write_all(pick_gain(1'b1), pick_gain(1'b1), pick_gain(1'b1),
					pick_gain(1'b1));
				5: write_all(16'sd4096, pick_gain(1'b1), 16'sd4096, pick_gain(1'b1));
				default: write_all(pick_gain(1'b0), pick_gain(1'b0), pick_gain(1'b0),
					pick_gain(1'b0));
			endcase
			if (p < 2) begin
				send_idle_pct = 13;
				rsp_idle_pct = 81;
			end else if (p < 4) begin
				send_idle_pct = 81;
				rsp_idle_pct = 13;
			end else begin
				send_idle_pct = 0;
				rsp_idle_pct = 0;
			end
			// long receiver hold-off so the pipe fills and backpressures
			if (p == 4)
				rsp_hold_cycles = 120;
			for (int n = 0; n < REQUESTS_PER_PHASE; n++)
				send_request(pick_velocity(), pick_velocity(), pick_yaw(),
					2'($urandom_range(3)));
			drain_requests();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatch_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: yaw_frame_foothold_offset_unit.f
rtl/core/ywfo_pkg.sv
rtl/core/ywfo_cordic_cell.sv
rtl/core/ywfo_offset_pipe.sv
rtl/core/yaw_frame_foothold_offset_unit.sv
sim/yaw_frame_foothold_offset_unit_tb.sv
